// File: src/kcc_pkg.sv
// Shared types and constants for the key click classifier.
package kcc_pkg;

	localparam int unsigned COUNT_WIDTH_DEFAULT = 10;
	localparam int unsigned REG_W = 10;
	localparam int unsigned CFG_INDEX_W = 3;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SHORT  = 2'd1,
		EV_LONG   = 2'd2,
		EV_DOUBLE = 2'd3
	} click_ev_t;

	localparam logic [CFG_INDEX_W-1:0] REG_LONG_HOLD_LIMIT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SHORT_MIN_HOLD  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAP_LOW_BOUND   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GAP_HIGH_BOUND  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_GAP_TIMEOUT     = 3'd4;

	localparam logic [REG_W-1:0] LONG_HOLD_LIMIT_RST = 10'd70;
	localparam logic [REG_W-1:0] SHORT_MIN_HOLD_RST  = 10'd3;
	localparam logic [REG_W-1:0] GAP_LOW_BOUND_RST   = 10'd3;
	localparam logic [REG_W-1:0] GAP_HIGH_BOUND_RST  = 10'd30;
	localparam logic [REG_W-1:0] GAP_TIMEOUT_RST     = 10'd500;

endpackage

// File: src/key_click_classifier_core.sv
// Key click classifier: sorts one key's presses into short, long and double clicks.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per timer tick, carrying press_edge
//   (a press edge seen since the last tick) and key_pressed (current key level).
//   Output channel (out_valid / out_stall): one item per input item, click_event
//   (none, short, long or double click), in input order.
//   Config port: cfg_write_en / cfg_index / cfg_data writes one limit register per
//   cycle; write only while no item is in flight.
// Timing:
//   The classifier state and the event are worked out in the cycle an item is
//   accepted; the event is registered in the output register, or in the skid
//   register during a stall. One item per cycle is sustained while in_stall is low.
// Stalls:
//   A two-entry output buffer (output register plus skid register) absorbs one
//   extra item while the receiver stalls; in_stall rises only when both are full.
// Reset:
//   arst_n clears the state, empties the output buffer and loads the default limits
//   (70, 3, 3, 30, 500).
module key_click_classifier_core #(
	parameter int unsigned COUNT_WIDTH = kcc_pkg::COUNT_WIDTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             press_edge,
	input  logic                             key_pressed,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       click_event,
	input  logic                             cfg_write_en,
	input  logic [kcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [kcc_pkg::REG_W-1:0]        cfg_data
);

	localparam int unsigned CMP_W =
		(COUNT_WIDTH > kcc_pkg::REG_W) ? COUNT_WIDTH : kcc_pkg::REG_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_TOP = '1;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	logic [kcc_pkg::REG_W-1:0] long_hold_limit_q;
	logic [kcc_pkg::REG_W-1:0] short_min_hold_q;
	logic [kcc_pkg::REG_W-1:0] gap_low_bound_q;
	logic [kcc_pkg::REG_W-1:0] gap_high_bound_q;
	logic [kcc_pkg::REG_W-1:0] gap_timeout_q;

	logic                   armed_q, armed_d;
	logic                   gap_running_q, gap_running_d;
	logic [COUNT_WIDTH-1:0] hold_count_q, hold_count_d;
	logic [COUNT_WIDTH-1:0] gap_count_q, gap_count_d;
	kcc_pkg::click_ev_t     ev_d;

	logic               out_valid_q;
	logic               skid_valid_q;
	kcc_pkg::click_ev_t out_ev_q;
	kcc_pkg::click_ev_t skid_ev_q;

	logic in_accept;
	logic out_take;

	assign in_stall    = skid_valid_q;
	assign in_accept   = in_valid & ~skid_valid_q;
	assign out_valid   = out_valid_q;
	assign out_take    = out_valid_q & ~out_stall;
	assign click_event = out_ev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold_limit_q <= kcc_pkg::LONG_HOLD_LIMIT_RST;
			short_min_hold_q  <= kcc_pkg::SHORT_MIN_HOLD_RST;
			gap_low_bound_q   <= kcc_pkg::GAP_LOW_BOUND_RST;
			gap_high_bound_q  <= kcc_pkg::GAP_HIGH_BOUND_RST;
			gap_timeout_q     <= kcc_pkg::GAP_TIMEOUT_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				kcc_pkg::REG_LONG_HOLD_LIMIT: long_hold_limit_q <= cfg_data;
				kcc_pkg::REG_SHORT_MIN_HOLD:  short_min_hold_q  <= cfg_data;
				kcc_pkg::REG_GAP_LOW_BOUND:   gap_low_bound_q   <= cfg_data;
				kcc_pkg::REG_GAP_HIGH_BOUND:  gap_high_bound_q  <= cfg_data;
				kcc_pkg::REG_GAP_TIMEOUT:     gap_timeout_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Tick update: press edge arms, then the armed logic, then the gap timer.
	always_comb begin
		armed_d       = armed_q | press_edge;
		hold_count_d  = hold_count_q;
		gap_count_d   = gap_count_q;
		gap_running_d = gap_running_q;
		ev_d          = kcc_pkg::EV_NONE;

		if (armed_d) begin
			if (key_pressed) begin
				gap_running_d = 1'b0;
				if (CMP_W'(hold_count_q) <= CMP_W'(long_hold_limit_q)) begin
					hold_count_d = (hold_count_q == CNT_TOP) ? CNT_TOP
						: hold_count_q + CNT_ONE;
				end else begin
					armed_d      = 1'b0;
					hold_count_d = '0;
					gap_count_d  = '0;
					ev_d         = kcc_pkg::EV_LONG;
				end
				// a long click has cleared the gap, so it wins over a double
				if (CMP_W'(gap_count_d) > CMP_W'(gap_low_bound_q) &&
				    CMP_W'(gap_count_d) < CMP_W'(gap_high_bound_q)) begin
					gap_count_d  = '0;
					hold_count_d = '0;
					ev_d         = kcc_pkg::EV_DOUBLE;
				end
			end else begin
				armed_d     = 1'b0;
				gap_count_d = '0;
				if (CMP_W'(hold_count_q) > CMP_W'(short_min_hold_q)) begin
					ev_d          = kcc_pkg::EV_SHORT;
					gap_running_d = 1'b1;
				end else begin
					gap_running_d = 1'b0;
				end
				hold_count_d = '0;
			end
		end

		if (gap_running_d) begin
			gap_count_d = (gap_count_d == CNT_TOP) ? CNT_TOP : gap_count_d + CNT_ONE;
		end
		if (CMP_W'(gap_count_d) > CMP_W'(gap_timeout_q)) begin
			gap_count_d   = '0;
			gap_running_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q       <= 1'b0;
			gap_running_q <= 1'b0;
			hold_count_q  <= '0;
			gap_count_q   <= '0;
		end else if (in_accept) begin
			armed_q       <= armed_d;
			gap_running_q <= gap_running_d;
			hold_count_q  <= hold_count_d;
			gap_count_q   <= gap_count_d;
		end
	end

	// Output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_accept) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_ev_q <= skid_ev_q;
			end
		end else if (in_accept) begin
			if (out_valid_q && !out_take) begin
				skid_ev_q <= ev_d;
			end else begin
				out_ev_q <= ev_d;
			end
		end
	end

endmodule
